// ===== rtl/core/aosf_pkg.sv =====
// aosf_pkg: shared types and widths for the audio output shaping filter
// used by aosf_mul, aosf_div and the top level; no dependencies
`default_nettype none

package aosf_pkg;

  // shared multiplier: wide signed operand times narrow unsigned operand
  localparam int MUL_A_W   = 50;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = 64;
  localparam int MUL_SPLIT = 25;

  // bit-serial divider
  localparam int DIV_N_W = 29;
  localparam int DIV_D_W = 18;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/aosf_mul.sv =====
// aosf_mul: shared multi-cycle multiplier, two partial products per operation
// depends on aosf_pkg
`default_nettype none

module aosf_mul import aosf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int HI_W = MUL_A_W - MUL_SPLIT;
  localparam int OP_W = MUL_SPLIT + 1;
  localparam int PP_W = OP_W + MUL_B_W + 1;

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_ACC} phase_t;

  phase_t             phase;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [PP_W-1:0]    pp;
  logic [MUL_P_W-1:0] prod;
  logic               done;

  logic signed [OP_W-1:0] op_a;
  logic signed [PP_W-1:0] pp_next;
  logic [MUL_P_W-1:0]     pp_ext;

  // low half zero extended, high half carries the sign
  always_comb begin
    if (phase == M_LO) begin
      op_a = $signed({1'b0, a_r[MUL_SPLIT-1:0]});
    end else begin
      op_a = $signed({{(OP_W-HI_W){a_r[MUL_A_W-1]}}, a_r[MUL_A_W-1:MUL_SPLIT]});
    end
  end

  assign pp_next = op_a * $signed({1'b0, b_r});
  assign pp_ext  = {{(MUL_P_W-PP_W){pp[PP_W-1]}}, pp};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= !req.start && (phase == M_ACC);
      if (req.start) begin
        a_r   <= req.a;
        b_r   <= req.b;
        phase <= M_LO;
      end else begin
        unique case (phase)
          M_IDLE: begin
          end
          M_LO: begin
            pp    <= pp_next;
            phase <= M_HI;
          end
          M_HI: begin
            prod  <= pp_ext;
            pp    <= pp_next;
            phase <= M_ACC;
          end
          M_ACC: begin
            prod  <= prod + (pp_ext << MUL_SPLIT);
            phase <= M_IDLE;
          end
          default: phase <= M_IDLE;
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

`default_nettype wire

// ===== rtl/core/aosf_div.sv =====
// aosf_div: restoring divider, one quotient bit per cycle
// depends on aosf_pkg
`default_nettype none

module aosf_div import aosf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] quo;
  logic [DIV_D_W-1:0] d_r;
  logic [CNT_W-1:0]   cnt;
  logic               done;

  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W+1:0] diff;
  logic               take;

  assign shifted = {rem, quo[DIV_N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign take    = ~diff[DIV_D_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !req.start && (cnt == CNT_W'(1));
      if (req.start) begin
        quo <= req.dividend;
        rem <= '0;
        d_r <= req.divisor;
        cnt <= CNT_W'(DIV_N_W);
      end else if (cnt != '0) begin
        rem <= take ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        quo <= {quo[DIV_N_W-2:0], take};
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/core/audio_output_shaping_filter.sv =====
// audio_output_shaping_filter: volume gain, two-accumulator dc-block / tone filter
// and optional one-pole low-pass; uses aosf_pkg, aosf_mul and aosf_div
`default_nettype none

// Each item is one signed 24-bit sample. It is scaled by the volume gain, run
// through a slow accumulator (follows the input, pole_one) and a shaping
// accumulator (follows the remainder, pole_two), both Q16 with round to
// nearest, and the output (slow - scaled input + shape) is rounded and
// saturated to 16 bits. With lowpass_enable set, a Q16 one-pole low-pass
// whose coefficient tracks the sample rate follows. The block works on one item
// at a time, paced by the single shared multiplier: each product is two 26x19
// partial products, then an accumulate, and an item needs three products (four
// with the low-pass) in sequence. The result sits in an output register, so
// the next item can be accepted while it waits. After any register write the
// block recomputes its coefficients in three divisions on a bit-serial
// divider; sample_ready stays low meanwhile. The volume gain comes from a
// constant reciprocal and needs no division. Registers sit at byte addresses
// 0 (sample_rate), 4 (volume_percent), 8 (quality_mode) and 12
// (lowpass_enable); a rate of 0 acts as 48000 Hz.
module audio_output_shaping_filter import aosf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample items in
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [23:0] sample,
  input  logic               block_end,
  // filtered items out
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] filtered,
  output logic               block_end_out
);

  // register map, by word address
  typedef enum logic [1:0] {
    REG_RATE,
    REG_VOLUME,
    REG_QUALITY,
    REG_LOWPASS
  } reg_index_t;

  // coefficient derivation order
  typedef enum logic [1:0] {
    DS_POLE_ONE,
    DS_POLE_TWO,
    DS_LOWPASS
  } derive_step_t;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for an item, gain product started on acceptance
    S_INO,    // scaled input ready, start slow product
    S_SLOW,   // update slow accumulator
    S_SHS,    // start shaping product
    S_SHAPE,  // update shaping accumulator
    S_SUM,    // slow - input + shape
    S_SAT,    // round and saturate
    S_LPS,    // start low-pass product
    S_LP,     // update low-pass accumulator
    S_LPY,    // low-pass output saturate
    S_FIN,    // hand result to the output register
    S_DV,     // start one coefficient division
    S_DW      // store coefficient
  } state_t;

  localparam logic [17:0]        RATE_DEFAULT  = 18'd48000;
  localparam logic [7:0]         VOL_DEFAULT   = 8'd100;
  localparam logic [DIV_N_W-1:0] POLE_ONE_NUM  = DIV_N_W'(94 * 65536);
  localparam logic [DIV_N_W-1:0] POLE_TWO_NUM  = DIV_N_W'(24 * 65536);
  localparam logic [DIV_N_W-1:0] LP_NUM        = DIV_N_W'(8192 * 48000);
  localparam logic [DIV_N_W-1:0] POLE_ONE_MAX  = DIV_N_W'(16383);
  localparam logic [DIV_N_W-1:0] POLE_TWO_MAX  = DIV_N_W'(4095);
  localparam logic [DIV_N_W-1:0] LP_COEFF_MAX  = DIV_N_W'(65536);
  // volume * 65536 * 3 / 400 = volume * 12288 / 25 = volume * 491 + volume * 13 / 25
  localparam logic [16:0]        GAIN_WHOLE    = 17'd491;
  localparam logic [11:0]        GAIN_REM      = 12'd13;
  // ceil(2^15 / 25), exact for numerators below 4681
  localparam logic [22:0]        RECIP_25      = 23'd1311;
  localparam logic [13:0]        POLE_ONE_RST  = 14'd128;
  localparam logic [11:0]        POLE_TWO_RST  = 12'd32;
  localparam logic [17:0]        GAIN_RST      = 18'd98304;
  localparam logic [16:0]        LP_COEFF_RST  = 17'd8192;
  localparam logic [16:0]        LP_COEFF_MAXC = 17'd65536;
  localparam logic [16:0]        LP_COEFF_MIN  = 17'd1;
  localparam logic [15:0]        SAT_POS       = 16'h7fff;
  localparam logic [15:0]        SAT_NEG       = 16'h8000;

  // configuration registers
  logic [17:0] sample_rate;
  logic [7:0]  volume_percent;
  logic [1:0]  quality_mode;
  logic        lowpass_enable;

  // derived coefficients
  logic [13:0] pole_one;
  logic [11:0] pole_two;
  logic [17:0] gain;
  logic [16:0] lowpass_coeff;

  // filter state and working registers
  state_t       state;
  derive_step_t dsel;
  logic [47:0]  slow_acc;
  logic [47:0]  shape_acc;
  logic [33:0]  lp_acc;
  logic [41:0]  ino;
  logic [49:0]  sum_r;
  logic [15:0]  y_val;
  logic         be_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        cfg_wr;
  reg_index_t  reg_idx;
  logic        sample_accept;
  logic [17:0] rate_eff;
  logic [11:0] gain_rem_n;
  logic [22:0] gain_rem_p;
  logic [16:0] gain_base;
  logic [49:0] ino_ext;
  logic [49:0] slow_ext;
  logic [49:0] shape_ext;
  logic [49:0] prod_ino_ext;
  logic [DIV_N_W-1:0] quo;

  // Q16 value with 16 fraction bits taken off, saturated to 16 bits
  function automatic logic [15:0] sat16(input logic [33:0] v);
    logic [15:0] r;
    if ($signed(v) > $signed(34'sd32767)) begin
      r = SAT_POS;
    end else if ($signed(v) < -$signed(34'sd32768)) begin
      r = SAT_NEG;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite;
  assign reg_idx       = reg_index_t'(paddr[3:2]);
  assign sample_ready  = (state == S_IDLE) && !cfg_wr;
  assign sample_accept = sample_valid && sample_ready;

  assign rate_eff     = (sample_rate == '0) ? RATE_DEFAULT : sample_rate;
  // volume * 65536 * 3 / 400, the remainder part divided by a reciprocal
  assign gain_rem_n   = 12'(volume_percent) * GAIN_REM;
  assign gain_rem_p   = 23'(gain_rem_n) * RECIP_25;
  assign gain_base    = 17'(volume_percent) * GAIN_WHOLE + 17'(gain_rem_p[22:15]);
  assign ino_ext      = {{8{ino[41]}}, ino};
  assign slow_ext     = {{2{slow_acc[47]}}, slow_acc};
  assign shape_ext    = {{2{shape_acc[47]}}, shape_acc};
  assign prod_ino_ext = {{8{mul_rsp.prod[41]}}, mul_rsp.prod[41:0]};
  assign quo          = div_rsp.quotient;

  // register writes and readback
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate    <= RATE_DEFAULT;
      volume_percent <= VOL_DEFAULT;
      quality_mode   <= '0;
      lowpass_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RATE:    sample_rate    <= pwdata[17:0];
        REG_VOLUME:  volume_percent <= pwdata[7:0];
        REG_QUALITY: quality_mode   <= pwdata[1:0];
        REG_LOWPASS: lowpass_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_RATE:    prdata = 32'(sample_rate);
      REG_VOLUME:  prdata = 32'(volume_percent);
      REG_QUALITY: prdata = 32'(quality_mode);
      REG_LOWPASS: prdata = 32'(lowpass_enable);
      default:     prdata = '0;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state)
      S_IDLE: begin
        mul_req.start = sample_accept;
        mul_req.a     = {{26{sample[23]}}, sample};
        mul_req.b     = gain;
      end
      S_INO: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = prod_ino_ext - slow_ext;
        mul_req.b     = 18'(pole_one);
      end
      S_SHS: begin
        mul_req.start = 1'b1;
        mul_req.a     = ino_ext - slow_ext - shape_ext;
        mul_req.b     = 18'(pole_two);
      end
      S_LPS: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{18{y_val[15]}}, y_val, 16'h0000} - {{16{lp_acc[33]}}, lp_acc};
        mul_req.b     = 18'(lowpass_coeff);
      end
      default: begin
      end
    endcase
  end

  // operand select for the divider
  always_comb begin
    div_req.start    = (state == S_DV);
    div_req.dividend = POLE_ONE_NUM;
    div_req.divisor  = rate_eff;
    unique case (dsel)
      DS_POLE_ONE: div_req.dividend = POLE_ONE_NUM;
      DS_POLE_TWO: div_req.dividend = POLE_TWO_NUM;
      DS_LOWPASS:  div_req.dividend = LP_NUM + DIV_N_W'(rate_eff >> 1);
      default:     div_req.dividend = POLE_ONE_NUM;
    endcase
  end

  aosf_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  aosf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dsel          <= DS_POLE_ONE;
      slow_acc      <= '0;
      shape_acc     <= '0;
      lp_acc        <= '0;
      pole_one      <= POLE_ONE_RST;
      pole_two      <= POLE_TWO_RST;
      gain          <= GAIN_RST;
      lowpass_coeff <= LP_COEFF_RST;
      result_valid  <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (result_ready && (state != S_FIN || cfg_wr)) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr) begin
        // any register write restarts coefficient derivation
        dsel  <= DS_POLE_ONE;
        state <= S_DV;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (sample_accept) begin
              be_r  <= block_end;
              state <= S_INO;
            end
          end
          S_INO: begin
            if (mul_rsp.done) begin
              ino   <= mul_rsp.prod[41:0];
              state <= S_SLOW;
            end
          end
          S_SLOW: begin
            // rounding: add bit 15 as carry into the Q16 integer part
            if (mul_rsp.done) begin
              slow_acc <= slow_acc + mul_rsp.prod[63:16] + 48'(mul_rsp.prod[15]);
              state    <= S_SHS;
            end
          end
          S_SHS: begin
            state <= S_SHAPE;
          end
          S_SHAPE: begin
            if (mul_rsp.done) begin
              shape_acc <= shape_acc + mul_rsp.prod[63:16] + 48'(mul_rsp.prod[15]);
              state     <= S_SUM;
            end
          end
          S_SUM: begin
            sum_r <= slow_ext - ino_ext + shape_ext;
            state <= S_SAT;
          end
          S_SAT: begin
            y_val <= sat16(sum_r[49:16] + 34'(sum_r[15]));
            state <= lowpass_enable ? S_LPS : S_FIN;
          end
          S_LPS: begin
            state <= S_LP;
          end
          S_LP: begin
            if (mul_rsp.done) begin
              lp_acc <= lp_acc + mul_rsp.prod[49:16] + 34'(mul_rsp.prod[15]);
              state  <= S_LPY;
            end
          end
          S_LPY: begin
            y_val <= sat16({{16{lp_acc[33]}}, lp_acc[33:16]});
            state <= S_FIN;
          end
          S_FIN: begin
            if (!result_valid || result_ready) begin
              filtered      <= y_val;
              block_end_out <= be_r;
              result_valid  <= 1'b1;
              state         <= S_IDLE;
            end
          end
          S_DV: begin
            state <= S_DW;
          end
          S_DW: begin
            if (div_rsp.done) begin
              unique case (dsel)
                DS_POLE_ONE: begin
                  pole_one <= (quo > POLE_ONE_MAX) ? POLE_ONE_MAX[13:0] : quo[13:0];
                  dsel     <= DS_POLE_TWO;
                  state    <= S_DV;
                end
                DS_POLE_TWO: begin
                  pole_two <= (quo > POLE_TWO_MAX) ? POLE_TWO_MAX[11:0] : quo[11:0];
                  dsel     <= DS_LOWPASS;
                  state    <= S_DV;
                end
                DS_LOWPASS: begin
                  if (quo == '0) begin
                    lowpass_coeff <= LP_COEFF_MIN;
                  end else if (quo > LP_COEFF_MAX) begin
                    lowpass_coeff <= LP_COEFF_MAXC;
                  end else begin
                    lowpass_coeff <= quo[16:0];
                  end
                  // low quality doubles the gain, any other mode quarters it
                  gain  <= (quality_mode != '0) ? {3'b000, gain_base[16:2]}
                                                : {gain_base, 1'b0};
                  dsel  <= DS_POLE_ONE;
                  state <= S_IDLE;
                end
                default: begin
                  dsel  <= DS_POLE_ONE;
                  state <= S_IDLE;
                end
              endcase
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_lp_coeff_range: assert property (@(posedge clk) disable iff (rst)
    (lowpass_coeff != '0) && (lowpass_coeff <= LP_COEFF_MAXC))
    else $error("low-pass coefficient out of range");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    sample_accept |=> !sample_ready)
    else $error("second item taken while one is in work");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !sample_ready)
    else $error("item taken before coefficients were rederived");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_INO || state == S_SLOW || state == S_SHAPE ||
                      state == S_LP))
    else $error("product finished outside a waiting state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DV || state == S_DW))
    else $error("quotient finished outside derivation");
`endif

endmodule

`default_nettype wire
